// ===== rtl/core/rbce_pkg.sv =====
// ----------------------------------------------------------------------------
// rbce_pkg
// Shared constants, types and functions of the RDS block checkword encoder.
// ----------------------------------------------------------------------------
package rbce_pkg;

    localparam int DATA_W  = 16;
    localparam int CHK_W   = 10;
    localparam int CODED_W = DATA_W + CHK_W;
    localparam int POS_W   = 2;

    localparam logic [CHK_W-1:0] CHK_POLY = 10'h1B9;

    localparam logic [POS_W-1:0] POS_A = 2'd0;
    localparam logic [POS_W-1:0] POS_B = 2'd1;
    localparam logic [POS_W-1:0] POS_C = 2'd2;
    localparam logic [POS_W-1:0] POS_D = 2'd3;

    localparam logic [CHK_W-1:0] OFFSET_A = 10'h0FC;
    localparam logic [CHK_W-1:0] OFFSET_B = 10'h198;
    localparam logic [CHK_W-1:0] OFFSET_C = 10'h168;
    localparam logic [CHK_W-1:0] OFFSET_D = 10'h1B4;

    localparam logic [CHK_W-1:0] CORRUPT_MASK = 10'h001;

    typedef logic [DATA_W-1:0][CHK_W-1:0] chk_cols_t;

    typedef struct packed {
        logic [CODED_W-1:0] diff_block;
        logic               level;
    } diff_result_t;

    // Checkword of each single-bit data word; the checkword is linear in the data.
    function automatic chk_cols_t chk_columns();
        chk_cols_t          cols;
        logic [CHK_W-1:0]   crc;
        logic [DATA_W-1:0]  word;
        logic               din;
        cols = '0;
        for (int k = 0; k < DATA_W; k++) begin
            word = DATA_W'(1) << k;
            crc  = '0;
            for (int i = 0; i < DATA_W; i++) begin
                din = word[DATA_W-1-i];
                if (din ^ crc[CHK_W-1]) begin
                    crc = (crc << 1) ^ CHK_POLY;
                end else begin
                    crc = crc << 1;
                end
            end
            cols[k] = crc;
        end
        return cols;
    endfunction

    localparam chk_cols_t CHK_COLUMN = chk_columns();

    function automatic logic [CHK_W-1:0] offset_word(input logic [POS_W-1:0] pos);
        logic [CHK_W-1:0] ofs;
        unique case (pos)
            POS_A:   ofs = OFFSET_A;
            POS_B:   ofs = OFFSET_B;
            POS_C:   ofs = OFFSET_C;
            POS_D:   ofs = OFFSET_D;
            default: ofs = OFFSET_A;
        endcase
        return ofs;
    endfunction

endpackage

// ===== rtl/core/rbce_checkword.sv =====
// ----------------------------------------------------------------------------
// rbce_checkword
// Builds the 26-bit coded block: data word, then offset-XORed checkword.
// ----------------------------------------------------------------------------
module rbce_checkword (
    input  logic [rbce_pkg::DATA_W-1:0]  block_data,
    input  logic [rbce_pkg::POS_W-1:0]   block_position,
    input  logic                         corrupt_first_check,
    output logic [rbce_pkg::CODED_W-1:0] coded_block
);

    logic [rbce_pkg::CHK_W-1:0] crc;
    logic [rbce_pkg::CHK_W-1:0] chk;

    always_comb begin
        crc = '0;
        for (int k = 0; k < rbce_pkg::DATA_W; k++) begin
            if (block_data[k]) begin
                crc = crc ^ rbce_pkg::CHK_COLUMN[k];
            end
        end
    end

    always_comb begin
        chk = crc ^ rbce_pkg::offset_word(block_position);
        if (corrupt_first_check && (block_position == rbce_pkg::POS_A)) begin
            chk = chk ^ rbce_pkg::CORRUPT_MASK;
        end
    end

    assign coded_block = {block_data, chk};

endmodule

// ===== rtl/core/rbce_diff_encoder.sv =====
// ----------------------------------------------------------------------------
// rbce_diff_encoder
// Differential encoding of a coded block, bit 25 first, from a carried level.
// ----------------------------------------------------------------------------
module rbce_diff_encoder (
    input  logic [rbce_pkg::CODED_W-1:0] coded_block,
    input  logic                         level_in,
    output rbce_pkg::diff_result_t       result
);

    logic [rbce_pkg::CODED_W-1:0] diff;

    always_comb begin
        for (int b = 0; b < rbce_pkg::CODED_W; b++) begin
            diff[b] = level_in ^ (^(coded_block >> b));
        end
    end

    assign result.diff_block = diff;
    assign result.level      = diff[0];

endmodule

// ===== rtl/core/rds_block_checkword_encoder.sv =====
// ----------------------------------------------------------------------------
// rds_block_checkword_encoder
// RDS block checkword, offset and differential encoder; one block per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_        | in        | tdata: block_data[15:0]; tuser: block_position[1:0]
//  m_        | out       | tdata: coded_block[25:0], diff_coded_block[51:26]
//  cfg_      | in        | data: corrupt_first_check
//
//  One block per cycle while the m_ side accepts them.
//  Input register feeds the checkword and differential logic, output register
//  holds the result; the differential level advances as a block enters it.
//  A stalled m_ side backs up into the input register, then drops s_tready.
//  aresetn clears valid flags, the level and corrupt_first_check.
// ----------------------------------------------------------------------------
module rds_block_checkword_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // block_data[15:0]
    input  logic [1:0]  s_tuser,    // block_position[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // coded_block[25:0], diff_coded_block[51:26], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data    // corrupt_first_check
);

    logic                          in_valid_reg;
    logic [rbce_pkg::DATA_W-1:0]   data_reg;
    logic [rbce_pkg::POS_W-1:0]    pos_reg;
    logic                          out_valid_reg;
    logic [rbce_pkg::CODED_W-1:0]  coded_reg;
    logic [rbce_pkg::CODED_W-1:0]  diff_reg;
    logic                          level_reg;
    logic                          corrupt_reg;

    logic                          out_free;
    logic                          load_out;
    logic [rbce_pkg::CODED_W-1:0]  coded_next;
    rbce_pkg::diff_result_t        diff_next;

    assign out_free  = !out_valid_reg || m_tready;
    assign load_out  = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    rbce_checkword u_checkword (
        .block_data          (data_reg),
        .block_position      (pos_reg),
        .corrupt_first_check (corrupt_reg),
        .coded_block         (coded_next)
    );

    rbce_diff_encoder u_diff (
        .coded_block (coded_next),
        .level_in    (level_reg),
        .result      (diff_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            level_reg     <= 1'b0;
            corrupt_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                corrupt_reg <= cfg_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (load_out) begin
                level_reg <= diff_next.level;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
            pos_reg  <= s_tuser;
        end
        if (load_out) begin
            coded_reg <= coded_next;
            diff_reg  <= diff_next.diff_block;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, diff_reg, coded_reg};

    // Level carried forward matches the last bit of the held result.
    a_level_tracks_output: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (level_reg == diff_reg[0]))
        else $error("differential level out of step with output");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> out_valid_reg)
        else $error("block lost on move to output register");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages are full");

    a_level_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !load_out |=> $stable(level_reg))
        else $error("differential level changed without a block");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!out_valid_reg && !in_valid_reg && !level_reg))
        else $error("reset did not clear control state");

endmodule

// ===== sim/rds_block_checkword_encoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rds_block_checkword_encoder_tb
// Self-checking bench for the RDS block checkword and differential encoder.
// A directed table walks the data extremes, every block position and both
// corrupt_first_check settings. Random blocks follow, mostly in A-B-C-D
// group order. Every coded and differential word is compared against a bench
// encoder that keeps its own line level. Both stream sides stall at random,
// and one long output hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module rds_block_checkword_encoder_tb;
    import rbce_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 60;
    localparam int RAND_PER_PHASE = 207;

    typedef struct packed {
        logic [CODED_W-1:0] coded;
        logic [CODED_W-1:0] diff;
    } rds_word_t;

    typedef struct packed {
        logic               is_cfg;
        logic               cfg_val;
        logic [DATA_W-1:0]  data;
        logic [POS_W-1:0]   pos;
        logic               typed;
        logic [CODED_W-1:0] coded;
    } block_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // block_data[15:0]
    logic [1:0]  s_tuser;    // block_position[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;    // coded_block[25:0], diff_coded_block[51:26], zero pad
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    rds_word_t   pending_blocks[$];
    logic        corrupt_a;
    logic        line_level;
    bit          idle_en;
    bit          hold_req;
    int          fail_count;
    int          stall_cycles;

    block_row_t  block_table[22] = '{
        '{1'b0, 1'b0, 16'h0000, POS_A, 1'b1, 26'h00000FC},
        '{1'b0, 1'b0, 16'h0000, POS_B, 1'b1, 26'h0000198},
        '{1'b0, 1'b0, 16'h0000, POS_C, 1'b1, 26'h0000168},
        '{1'b0, 1'b0, 16'h0000, POS_D, 1'b1, 26'h00001B4},
        '{1'b0, 1'b0, 16'hFFFF, POS_A, 1'b0, 26'h0},
        '{1'b0, 1'b0, 16'hFFFF, POS_B, 1'b0, 26'h0},
        '{1'b0, 1'b0, 16'hFFFF, POS_C, 1'b0, 26'h0},
        '{1'b0, 1'b0, 16'hFFFF, POS_D, 1'b0, 26'h0},
        '{1'b0, 1'b0, 16'h8000, POS_A, 1'b0, 26'h0},
        '{1'b0, 1'b0, 16'h0001, POS_B, 1'b0, 26'h0},
        '{1'b0, 1'b0, 16'hAAAA, POS_C, 1'b0, 26'h0},
        '{1'b0, 1'b0, 16'h5555, POS_D, 1'b0, 26'h0},
        '{1'b1, 1'b1, 16'h0000, POS_A, 1'b0, 26'h0},
        '{1'b0, 1'b0, 16'h0000, POS_A, 1'b1, 26'h00000FD},
        '{1'b0, 1'b0, 16'h0000, POS_B, 1'b1, 26'h0000198},
        '{1'b0, 1'b0, 16'h0000, POS_C, 1'b1, 26'h0000168},
        '{1'b0, 1'b0, 16'h0000, POS_D, 1'b1, 26'h00001B4},
        '{1'b0, 1'b0, 16'hFFFF, POS_A, 1'b0, 26'h0},
        '{1'b0, 1'b0, 16'h1234, POS_C, 1'b0, 26'h0},
        '{1'b1, 1'b0, 16'h0000, POS_A, 1'b0, 26'h0},
        '{1'b0, 1'b0, 16'h0000, POS_A, 1'b1, 26'h00000FC},
        '{1'b0, 1'b0, 16'hFFFF, POS_A, 1'b0, 26'h0}
    };

    rds_block_checkword_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Checkword, offset, optional block A corruption, then the line code.
    function automatic rds_word_t encode_block(input logic [DATA_W-1:0] data,
                                               input logic [POS_W-1:0] pos);
        rds_word_t        w;
        logic [CHK_W-1:0] crc;
        logic             fb;
        crc = '0;
        for (int i = DATA_W - 1; i >= 0; i--) begin
            fb  = data[i] ^ crc[CHK_W-1];
            crc = crc << 1;
            if (fb) begin
                crc = crc ^ CHK_POLY;
            end
        end
        case (pos)
            POS_A:   crc = crc ^ OFFSET_A;
            POS_B:   crc = crc ^ OFFSET_B;
            POS_C:   crc = crc ^ OFFSET_C;
            default: crc = crc ^ OFFSET_D;
        endcase
        if (corrupt_a && pos == POS_A) begin
            crc = crc ^ CORRUPT_MASK;
        end
        w.coded = {data, crc};
        for (int b = CODED_W - 1; b >= 0; b--) begin
            line_level = line_level ^ w.coded[b];
            w.diff[b]  = line_level;
        end
        return w;
    endfunction

    task automatic wait_drain();
        while (pending_blocks.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_corrupt(input logic val);
        s_tvalid = 1'b0;
        wait_drain();
        cfg_valid = 1'b1;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        corrupt_a = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_block(input logic [DATA_W-1:0] data, input logic [POS_W-1:0] pos,
                              input logic typed, input logic [CODED_W-1:0] coded);
        rds_word_t w;
        if (idle_en && !hold_req && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = data;
        s_tuser  = pos;
        do @(posedge aclk); while (!s_tready);
        w = encode_block(data, pos);
        if (typed) begin
            w.coded = coded;
        end
        pending_blocks.push_back(w);
        @(negedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            default: return DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Output side: random stall bursts, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
                @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        rds_word_t w;
        if (!aresetn) begin
            stall_cycles <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_blocks.size() == 0) begin
                    $display("%0t: unexpected block %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    w = pending_blocks.pop_front();
                    if (m_tdata[25:0] !== w.coded) begin
                        $display("%0t: coded_block expected %h actual %h",
                                 $time, w.coded, m_tdata[25:0]);
                        fail_count++;
                    end
                    if (m_tdata[51:26] !== w.diff) begin
                        $display("%0t: diff_coded_block expected %h actual %h",
                                 $time, w.diff, m_tdata[51:26]);
                        fail_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [POS_W-1:0] grp_pos;
        logic [POS_W-1:0] pos;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = 1'b0;
        corrupt_a  = 1'b0;
        line_level = 1'b0;
        idle_en    = 1'b1;
        hold_req   = 1'b0;
        fail_count = 0;
        grp_pos    = POS_A;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (block_table[i]) begin
            if (block_table[i].is_cfg) begin
                write_corrupt(block_table[i].cfg_val);
            end else begin
                send_block(block_table[i].data, block_table[i].pos,
                           block_table[i].typed, block_table[i].coded);
            end
        end

        for (int phase = 0; phase < 4; phase++) begin
            write_corrupt(phase[0]);
            idle_en = (phase != 3);
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (phase == 1 && n == 60) begin
                    hold_req = 1'b1;
                end
                if (phase == 2 && n == 100) begin
                    s_tvalid = 1'b0;
                    wait_drain();
                end
                if ($urandom_range(0, 7) == 0) begin
                    pos = POS_W'($urandom_range(0, 3));
                end else begin
                    pos     = grp_pos;
                    grp_pos = grp_pos + 1'b1;
                end
                send_block(pick_data(), pos, 1'b0, '0);
            end
        end
        s_tvalid = 1'b0;

        wait_drain();
        repeat (5) @(negedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
